/* rtl/ts_pcr_pkg.sv */
// ----------------------------------------------------------------------------
// ts_pcr_pkg
// Shared types and constants of the transport stream clock interpolator.
// ----------------------------------------------------------------------------
package ts_pcr_pkg;

  localparam int HISTORY_DEPTH = 3;
  localparam int CLK_W         = 33;
  localparam int IDX_W         = 32;
  localparam int RATE_W        = 64;
  localparam int ALU_W         = RATE_W + 1;
  localparam int DIV_STEPS     = RATE_W;
  localparam int MUL_STEPS     = CLK_W;
  localparam int CNT_W         = $clog2(DIV_STEPS);

  // header decode
  localparam int          ADAPT_PRESENT_BIT = 5;
  localparam int          PCR_FLAG_BIT      = 4;
  localparam int          PCR_LOW_BIT       = 7;
  localparam logic [7:0]  MIN_ADAPT_LEN     = 8'd7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DC,
    S_DI,
    S_DIV,
    S_ELAP,
    S_MUL,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [CLK_W-1:0] newest_clk;
    logic [IDX_W-1:0] newest_idx;
    logic [CLK_W-1:0] oldest_clk;
    logic [IDX_W-1:0] oldest_idx;
  } hist_view_t;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

endpackage

/* rtl/ts_pcr_if.sv */
// ----------------------------------------------------------------------------
// ts_pcr_if
// Valid/ready channels for packet header beats and clock estimate beats.
// ----------------------------------------------------------------------------
interface ts_pcr_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  adaptation_control_byte;
  logic [7:0]  adaptation_length;
  logic [7:0]  adaptation_flags;
  logic [31:0] clock_high_bytes;
  logic [7:0]  clock_low_byte;
  logic [31:0] packet_index;

  modport source (
    output valid, adaptation_control_byte, adaptation_length, adaptation_flags,
           clock_high_bytes, clock_low_byte, packet_index,
    input  ready
  );
  modport sink (
    input  valid, adaptation_control_byte, adaptation_length, adaptation_flags,
           clock_high_bytes, clock_low_byte, packet_index,
    output ready
  );
endinterface

interface ts_pcr_out_if;
  logic        valid;
  logic        ready;
  logic [32:0] clock_estimate;
  logic        estimate_valid;
  logic        clock_taken;

  modport source (
    output valid, clock_estimate, estimate_valid, clock_taken,
    input  ready
  );
  modport sink (
    input  valid, clock_estimate, estimate_valid, clock_taken,
    output ready
  );
endinterface

/* rtl/ts_pcr_alu.sv */
// ----------------------------------------------------------------------------
// ts_pcr_alu
// Shared adder/subtractor used by the difference, divide, elapsed and multiply steps.
// ----------------------------------------------------------------------------
module ts_pcr_alu
  import ts_pcr_pkg::*;
(
  input  alu_req_t         req_i,
  output logic [ALU_W-1:0] y_o,
  output logic             carry_o
);

  logic [ALU_W-1:0] b_eff;
  logic [ALU_W:0]   sum;

  // subtract as a plus inverted b plus one; carry set means no borrow
  assign b_eff = req_i.sub ? ~req_i.b : req_i.b;
  assign sum   = {1'b0, req_i.a} + {1'b0, b_eff} + (ALU_W + 1)'(req_i.sub);
  assign y_o     = sum[ALU_W-1:0];
  assign carry_o = sum[ALU_W];

endmodule

/* rtl/ts_pcr_hist.sv */
// ----------------------------------------------------------------------------
// ts_pcr_hist
// History of stored clock values and packet numbers, newest at the top.
// ----------------------------------------------------------------------------
module ts_pcr_hist
  import ts_pcr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [CLK_W-1:0] clk_val_i,
  input  logic [IDX_W-1:0] idx_val_i,
  output hist_view_t       view_o
);

  logic [CLK_W-1:0] clk_q [HISTORY_DEPTH];
  logic [IDX_W-1:0] idx_q [HISTORY_DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        clk_q[k] <= '0;
        idx_q[k] <= '0;
      end
    end else if (push_i) begin
      for (int k = 0; k + 1 < HISTORY_DEPTH; k++) begin
        clk_q[k] <= clk_q[k+1];
        idx_q[k] <= idx_q[k+1];
      end
      clk_q[HISTORY_DEPTH-1] <= clk_val_i;
      idx_q[HISTORY_DEPTH-1] <= idx_val_i;
    end
  end

  assign view_o.newest_clk = clk_q[HISTORY_DEPTH-1];
  assign view_o.newest_idx = idx_q[HISTORY_DEPTH-1];
  assign view_o.oldest_clk = clk_q[0];
  assign view_o.oldest_idx = idx_q[0];

endmodule

/* rtl/ts_pcr_extract_interpolate.sv */
// ----------------------------------------------------------------------------
// ts_pcr_extract_interpolate
// Clock reference extraction, ticks-per-packet rate by serial division and
// per-packet clock estimate by serial shift-and-add multiplication.
// ----------------------------------------------------------------------------
// latency from accept to result beat covers the clock and index differences and
// 64 radix-2 divide steps on the shared adder with a rate update, then the
// elapsed count and 33 multiply steps; the multiply is skipped before any rate exists
// flow: one packet in flight; the result waits while the output beat is held
// reset: asynchronous, clears history, rate and all handshake state
module ts_pcr_extract_interpolate
  import ts_pcr_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  ts_pcr_in_if.sink    in_i,
  ts_pcr_out_if.source out_o
);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              taken_q, taken_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [RATE_W-1:0] quo_q, quo_d;
  logic [RATE_W-1:0] rem_q, rem_d;
  logic [RATE_W-1:0] dvs_q, dvs_d;
  logic [RATE_W-1:0] tpp_q, tpp_d;
  logic              rdy_q, rdy_d;
  logic [CLK_W-1:0]  acc_q, acc_d;
  logic [CLK_W-1:0]  mcand_q, mcand_d;
  logic [CLK_W-1:0]  mplier_q, mplier_d;
  logic              ov_q, ov_d;
  logic [CLK_W-1:0]  oest_q, oest_d;
  logic              ordy_q, ordy_d;
  logic              otaken_q, otaken_d;

  logic             take;
  logic             push;
  logic             load;
  logic [CLK_W-1:0] new_clk;
  hist_view_t       hist;
  alu_req_t         alu_req;
  logic [ALU_W-1:0] alu_y;
  logic             alu_c;

  assign take = in_i.adaptation_control_byte[ADAPT_PRESENT_BIT]
              && (in_i.adaptation_length >= MIN_ADAPT_LEN)
              && in_i.adaptation_flags[PCR_FLAG_BIT];
  assign new_clk = {in_i.clock_high_bytes, in_i.clock_low_byte[PCR_LOW_BIT]};
  assign push    = in_i.valid && in_i.ready && take;

  ts_pcr_hist u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .clk_val_i (new_clk),
    .idx_val_i (in_i.packet_index),
    .view_o    (hist)
  );

  ts_pcr_alu u_alu (
    .req_i   (alu_req),
    .y_o     (alu_y),
    .carry_o (alu_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      tpp_q   <= '0;
      rdy_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      tpp_q   <= tpp_d;
      rdy_q   <= rdy_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    taken_q  <= taken_d;
    idx_q    <= idx_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    dvs_q    <= dvs_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    oest_q   <= oest_d;
    ordy_q   <= ordy_d;
    otaken_q <= otaken_d;
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    taken_d    = taken_q;
    idx_d      = idx_q;
    quo_d      = quo_q;
    rem_d      = rem_q;
    dvs_d      = dvs_q;
    tpp_d      = tpp_q;
    rdy_d      = rdy_q;
    acc_d      = acc_q;
    mcand_d    = mcand_q;
    mplier_d   = mplier_q;
    alu_req    = '0;
    in_i.ready = 1'b0;
    load       = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          taken_d = take;
          idx_d   = in_i.packet_index;
          state_d = S_DC;
        end
      end
      S_DC: begin
        // clock difference, wraps at 64 bits
        alu_req.a   = ALU_W'(hist.newest_clk);
        alu_req.b   = ALU_W'(hist.oldest_clk);
        alu_req.sub = 1'b1;
        if (taken_q && (hist.oldest_idx != '0) && (hist.newest_idx != hist.oldest_idx)) begin
          quo_d   = alu_y[RATE_W-1:0];
          state_d = S_DI;
        end else begin
          state_d = S_ELAP;
        end
      end
      S_DI: begin
        alu_req.a   = ALU_W'(hist.newest_idx);
        alu_req.b   = ALU_W'(hist.oldest_idx);
        alu_req.sub = 1'b1;
        dvs_d       = alu_y[RATE_W-1:0];
        rem_d       = '0;
        cnt_d       = '0;
        state_d     = S_DIV;
      end
      S_DIV: begin
        // restoring step: shift in next dividend bit, try subtract
        alu_req.a   = {rem_q, quo_q[RATE_W-1]};
        alu_req.b   = {1'b0, dvs_q};
        alu_req.sub = 1'b1;
        rem_d = alu_c ? alu_y[RATE_W-1:0] : {rem_q[RATE_W-2:0], quo_q[RATE_W-1]};
        quo_d = {quo_q[RATE_W-2:0], alu_c};
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          tpp_d   = {quo_q[RATE_W-2:0], alu_c};
          rdy_d   = 1'b1;
          state_d = S_ELAP;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_ELAP: begin
        // only the low clock bits of the elapsed count matter after masking
        alu_req.a   = ALU_W'(idx_q);
        alu_req.b   = ALU_W'(hist.newest_idx);
        alu_req.sub = 1'b1;
        mplier_d    = alu_y[CLK_W-1:0];
        mcand_d     = tpp_q[CLK_W-1:0];
        cnt_d       = '0;
        if (rdy_q) begin
          acc_d   = hist.newest_clk;
          state_d = S_MUL;
        end else begin
          acc_d   = '0;
          state_d = S_DONE;
        end
      end
      S_MUL: begin
        alu_req.a = ALU_W'(acc_q);
        alu_req.b = ALU_W'(mcand_q);
        if (mplier_q[0]) begin
          acc_d = alu_y[CLK_W-1:0];
        end
        mcand_d  = {mcand_q[CLK_W-2:0], 1'b0};
        mplier_d = {1'b0, mplier_q[CLK_W-1:1]};
        if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DONE: begin
        if (!ov_q || out_o.ready) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    ov_d     = ov_q;
    oest_d   = oest_q;
    ordy_d   = ordy_q;
    otaken_d = otaken_q;
    if (load) begin
      ov_d     = 1'b1;
      oest_d   = acc_q;
      ordy_d   = rdy_q;
      otaken_d = taken_q;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  assign out_o.valid          = ov_q;
  assign out_o.clock_estimate = oest_q;
  assign out_o.estimate_valid = ordy_q;
  assign out_o.clock_taken    = otaken_q;

`ifndef SYNTH
  a_rate_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(rdy_q))
    else $error("rate ready dropped");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_i.ready)
    else $error("input ready while packet in flight");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!ov_q || out_o.ready))
    else $error("result overwrote pending beat");

  a_zero_est: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !ordy_q) |-> (oest_q == '0))
    else $error("estimate nonzero without rate");

  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DI) |=> (state_q == S_DIV && cnt_q == '0))
    else $error("divider started out of step");
`endif

endmodule
